>>> sv/rsc_pkg.sv
package rsc_pkg;

  // fixed field widths
  localparam int DATA_W = 32;
  localparam int CODE_W = 3;

  // iterative unit sizing: Q16.16 divide gives 48 quotient bits, sqrt 24 root bits
  localparam int SH_W       = 48;
  localparam int REM_W      = 34;
  localparam int ROOT_W     = 24;
  localparam int ITER_W     = 6;
  localparam int DIV_STEPS  = 48;
  localparam int SQRT_STEPS = 24;

  // token kinds
  localparam logic [CODE_W-1:0] KIND_PUSH = 3'd0;
  localparam logic [CODE_W-1:0] KIND_ADD  = 3'd1;
  localparam logic [CODE_W-1:0] KIND_SUB  = 3'd2;
  localparam logic [CODE_W-1:0] KIND_MUL  = 3'd3;
  localparam logic [CODE_W-1:0] KIND_DIV  = 3'd4;
  localparam logic [CODE_W-1:0] KIND_SQRT = 3'd5;
  localparam logic [CODE_W-1:0] KIND_END  = 3'd6;

  // status / held error codes
  localparam logic [CODE_W-1:0] ERR_NONE = 3'd0;
  localparam logic [CODE_W-1:0] ERR_FEW  = 3'd1;
  localparam logic [CODE_W-1:0] ERR_DIV0 = 3'd2;
  localparam logic [CODE_W-1:0] ERR_NEG  = 3'd3;
  localparam logic [CODE_W-1:0] ERR_OVF  = 3'd4;
  localparam logic [CODE_W-1:0] ERR_LEFT = 3'd5;

  // saturation limits
  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [CODE_W-1:0]        kind;
    logic signed [DATA_W-1:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]        status;
    logic signed [DATA_W-1:0] answer;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_B,
    ST_RD_A,
    ST_LOAD,
    ST_ITER,
    ST_FIN,
    ST_END_RD,
    ST_END_OUT
  } state_t;

endpackage

>>> sv/rpn_stack_calculator_core.sv
// steps: push written on acceptance; add/sub/mul RD_B, RD_A, LOAD, FIN; divide also ITER;
//   sqrt RD_B, LOAD, ITER, FIN; end token END_RD, END_OUT (plus any wait for out_ready)
// throughput: one item at a time; divide and sqrt run one quotient or root bit per
//   cycle through a single shared compare/subtract unit, which sets the rate
// reset: synchronous active-low rst_n empties the stack and clears the held error;
//   stack entries themselves are not cleared
module rpn_stack_calculator_core #(
  parameter int STACK_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rsc_pkg::out_item_t  out_data
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  // control registers
  rsc_pkg::state_t              state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [rsc_pkg::CODE_W-1:0]   err_r, err_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // payload registers
  logic [rsc_pkg::CODE_W-1:0]       kind_r, kind_nxt;
  logic signed [rsc_pkg::DATA_W-1:0] a_r, a_nxt;
  logic signed [rsc_pkg::DATA_W-1:0] b_r, b_nxt;
  logic signed [63:0]               prod_r, prod_nxt;
  logic [rsc_pkg::SH_W-1:0]         sh_r, sh_nxt;
  logic [rsc_pkg::REM_W-1:0]        rem_r, rem_nxt;
  logic [rsc_pkg::ROOT_W-1:0]       root_r, root_nxt;
  logic [rsc_pkg::DATA_W-1:0]       dvs_r, dvs_nxt;
  logic                             neg_r, neg_nxt;
  logic [rsc_pkg::ITER_W-1:0]       iter_r, iter_nxt;
  rsc_pkg::out_item_t               out_data_r, out_data_nxt;

  // operand stack memory
  logic [rsc_pkg::DATA_W-1:0] mem [STACK_DEPTH];
  logic [rsc_pkg::DATA_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  logic [rsc_pkg::DATA_W-1:0] wr_data;

  // misc combinational
  logic                             accept;
  logic                             slot_free;
  logic                             in_binary;
  logic                             kind_binary;
  logic [CNT_W-1:0]                 cnt_m1;
  logic [CNT_W-1:0]                 cnt_m2;
  logic [rsc_pkg::DATA_W-1:0]       rd_mag;
  logic [rsc_pkg::DATA_W-1:0]       b_mag;
  logic signed [63:0]               mul_full;
  logic signed [63:0]               prod_sh;
  logic signed [32:0]               sum_full;
  logic [rsc_pkg::DATA_W-1:0]       fin_val;
  logic [rsc_pkg::REM_W-1:0]        rem_sh;
  logic [rsc_pkg::REM_W-1:0]        sub_opd;
  logic [rsc_pkg::REM_W:0]          step_diff;
  logic                             step_ge;
  logic [rsc_pkg::CODE_W-1:0]       end_status;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == rsc_pkg::ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_binary = (in_data.kind == rsc_pkg::KIND_ADD) || (in_data.kind == rsc_pkg::KIND_SUB) ||
                     (in_data.kind == rsc_pkg::KIND_MUL) || (in_data.kind == rsc_pkg::KIND_DIV);
  assign kind_binary = (kind_r == rsc_pkg::KIND_ADD) || (kind_r == rsc_pkg::KIND_SUB) ||
                       (kind_r == rsc_pkg::KIND_MUL) || (kind_r == rsc_pkg::KIND_DIV);
  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign cnt_m2 = cnt_r - CNT_W'(2);

  // magnitudes for the divider
  assign rd_mag = rd_data_r[31] ? (~rd_data_r + 32'd1) : rd_data_r;
  assign b_mag  = b_r[31] ? (~b_r + 32'd1) : b_r;

  // single multiplier, operands straight from registers
  assign mul_full = $signed(rd_data_r) * b_r;
  assign prod_sh  = prod_r >>> 16;

  // add / subtract in 33 bits
  assign sum_full = (kind_r == rsc_pkg::KIND_SUB) ? (a_r - b_r) : (a_r + b_r);

  // shared compare/subtract step for divide and sqrt
  always_comb begin
    if (kind_r == rsc_pkg::KIND_DIV) begin
      rem_sh  = {rem_r[32:0], sh_r[47]};
      sub_opd = {2'b00, dvs_r};
    end else begin
      rem_sh  = {rem_r[31:0], sh_r[47:46]};
      sub_opd = {8'b0, root_r, 2'b01};
    end
    step_diff = {1'b0, rem_sh} - {1'b0, sub_opd};
  end
  assign step_ge = !step_diff[rsc_pkg::REM_W];

  // result of the finished operation, saturated
  always_comb begin
    unique case (kind_r)
      rsc_pkg::KIND_ADD, rsc_pkg::KIND_SUB: begin
        if (sum_full[32] != sum_full[31]) begin
          fin_val = sum_full[32] ? rsc_pkg::SAT_MIN : rsc_pkg::SAT_MAX;
        end else begin
          fin_val = sum_full[31:0];
        end
      end
      rsc_pkg::KIND_MUL: begin
        if (prod_sh[63:31] != {33{prod_sh[31]}}) begin
          fin_val = prod_sh[63] ? rsc_pkg::SAT_MIN : rsc_pkg::SAT_MAX;
        end else begin
          fin_val = prod_sh[31:0];
        end
      end
      rsc_pkg::KIND_DIV: begin
        if (!neg_r) begin
          fin_val = (|sh_r[47:31]) ? rsc_pkg::SAT_MAX : {1'b0, sh_r[30:0]};
        end else if (sh_r > 48'h0000_8000_0000) begin
          fin_val = rsc_pkg::SAT_MIN;
        end else begin
          fin_val = ~sh_r[31:0] + 32'd1;
        end
      end
      default: begin
        fin_val = {8'b0, root_r};
      end
    endcase
  end

  // status of the end token
  always_comb begin
    if (err_r != rsc_pkg::ERR_NONE) begin
      end_status = err_r;
    end else if (cnt_r == CNT_W'(1)) begin
      end_status = rsc_pkg::ERR_NONE;
    end else begin
      end_status = rsc_pkg::ERR_LEFT;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.kind == rsc_pkg::KIND_END) begin
            state_nxt = rsc_pkg::ST_END_RD;
          end else if (err_r != rsc_pkg::ERR_NONE) begin
            state_nxt = rsc_pkg::ST_IDLE;
          end else if (in_data.kind == rsc_pkg::KIND_SQRT && cnt_r != '0) begin
            state_nxt = rsc_pkg::ST_RD_B;
          end else if (in_binary && cnt_r >= CNT_W'(2)) begin
            state_nxt = rsc_pkg::ST_RD_B;
          end
        end
      end
      rsc_pkg::ST_RD_B: begin
        state_nxt = (kind_r == rsc_pkg::KIND_SQRT) ? rsc_pkg::ST_LOAD : rsc_pkg::ST_RD_A;
      end
      rsc_pkg::ST_RD_A: begin
        state_nxt = rsc_pkg::ST_LOAD;
      end
      rsc_pkg::ST_LOAD: begin
        if (kind_r == rsc_pkg::KIND_DIV) begin
          state_nxt = (b_r == '0) ? rsc_pkg::ST_IDLE : rsc_pkg::ST_ITER;
        end else if (kind_r == rsc_pkg::KIND_SQRT) begin
          state_nxt = rd_data_r[31] ? rsc_pkg::ST_IDLE : rsc_pkg::ST_ITER;
        end else begin
          state_nxt = rsc_pkg::ST_FIN;
        end
      end
      rsc_pkg::ST_ITER: begin
        if (iter_r == '0) begin
          state_nxt = rsc_pkg::ST_FIN;
        end
      end
      rsc_pkg::ST_FIN: begin
        state_nxt = rsc_pkg::ST_IDLE;
      end
      rsc_pkg::ST_END_RD: begin
        state_nxt = rsc_pkg::ST_END_OUT;
      end
      rsc_pkg::ST_END_OUT: begin
        if (slot_free) begin
          state_nxt = rsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rsc_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    kind_nxt      = kind_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    prod_nxt      = prod_r;
    sh_nxt        = sh_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    dvs_nxt       = dvs_r;
    neg_nxt       = neg_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[ADDR_W-1:0];
    wr_data       = in_data.operand;

    unique case (state_r)
      rsc_pkg::ST_IDLE: begin
        if (accept) begin
          kind_nxt = in_data.kind;
          if (in_data.kind != rsc_pkg::KIND_END && err_r == rsc_pkg::ERR_NONE) begin
            // push, or operand count check
            if (in_data.kind == rsc_pkg::KIND_PUSH) begin
              if (cnt_r == CNT_W'(STACK_DEPTH)) begin
                err_nxt = rsc_pkg::ERR_OVF;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end else if (in_data.kind == rsc_pkg::KIND_SQRT && cnt_r == '0) begin
              err_nxt = rsc_pkg::ERR_FEW;
            end else if (in_binary && cnt_r < CNT_W'(2)) begin
              err_nxt = rsc_pkg::ERR_FEW;
            end
          end
        end
      end
      rsc_pkg::ST_RD_B: begin
        rd_addr = cnt_m1[ADDR_W-1:0];
      end
      rsc_pkg::ST_RD_A: begin
        rd_addr = cnt_m2[ADDR_W-1:0];
        b_nxt   = rd_data_r;
      end
      rsc_pkg::ST_LOAD: begin
        a_nxt    = rd_data_r;
        prod_nxt = mul_full;
        rem_nxt  = '0;
        root_nxt = '0;
        if (kind_r == rsc_pkg::KIND_DIV) begin
          if (b_r == '0) begin
            err_nxt = rsc_pkg::ERR_DIV0;
          end
          sh_nxt   = {rd_mag, 16'b0};
          dvs_nxt  = b_mag;
          neg_nxt  = rd_data_r[31] ^ b_r[31];
          iter_nxt = rsc_pkg::ITER_W'(rsc_pkg::DIV_STEPS - 1);
        end else begin
          if (kind_r == rsc_pkg::KIND_SQRT && rd_data_r[31]) begin
            err_nxt = rsc_pkg::ERR_NEG;
          end
          sh_nxt   = {rd_data_r, 16'b0};
          iter_nxt = rsc_pkg::ITER_W'(rsc_pkg::SQRT_STEPS - 1);
        end
      end
      rsc_pkg::ST_ITER: begin
        // one quotient or root bit per cycle
        rem_nxt  = step_ge ? step_diff[rsc_pkg::REM_W-1:0] : rem_sh;
        iter_nxt = iter_r - rsc_pkg::ITER_W'(1);
        if (kind_r == rsc_pkg::KIND_DIV) begin
          sh_nxt = {sh_r[46:0], step_ge};
        end else begin
          sh_nxt   = {sh_r[45:0], 2'b00};
          root_nxt = {root_r[22:0], step_ge};
        end
      end
      rsc_pkg::ST_FIN: begin
        wr_en   = 1'b1;
        wr_data = fin_val;
        if (kind_binary) begin
          wr_addr = cnt_m2[ADDR_W-1:0];
          cnt_nxt = cnt_m1;
        end else begin
          wr_addr = cnt_m1[ADDR_W-1:0];
        end
      end
      rsc_pkg::ST_END_RD: begin
        rd_addr = '0;
      end
      rsc_pkg::ST_END_OUT: begin
        if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = end_status;
          out_data_nxt.answer = (end_status == rsc_pkg::ERR_NONE) ? rd_data_r : '0;
          cnt_nxt             = '0;
          err_nxt             = rsc_pkg::ERR_NONE;
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsc_pkg::ST_IDLE;
      cnt_r       <= '0;
      err_r       <= rsc_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    prod_r     <= prod_nxt;
    sh_r       <= sh_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    dvs_r      <= dvs_nxt;
    neg_r      <= neg_nxt;
    iter_r     <= iter_nxt;
    out_data_r <= out_data_nxt;
  end

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_rd_b_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rsc_pkg::ST_RD_B |-> cnt_r != '0)
    else $error("top read on empty stack");

  a_rd_a_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rsc_pkg::ST_RD_A |-> cnt_r >= CNT_W'(2))
    else $error("second read with fewer than two entries");

  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != rsc_pkg::ERR_NONE |-> (state_r == rsc_pkg::ST_IDLE ||
      state_r == rsc_pkg::ST_END_RD || state_r == rsc_pkg::ST_END_OUT))
    else $error("operation running with held error");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == rsc_pkg::ST_END_OUT && cnt_r == '0 &&
      err_r == rsc_pkg::ERR_NONE)
    else $error("result without end token cleanup");

endmodule

>>> dv/rpn_checker.sv
module rpn_checker #(
  parameter int DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  rsc_pkg::in_item_t   in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  rsc_pkg::out_item_t  out_data,
  output int                  mismatches,
  output int                  pending
);

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  // shadow copy of the operand stack and held error
  logic signed [rsc_pkg::DATA_W-1:0] shadow_stack [DEPTH];
  int                                shadow_count;
  logic [rsc_pkg::CODE_W-1:0]        shadow_err;
  rsc_pkg::out_item_t                answers_q [$];

  function automatic logic signed [rsc_pkg::DATA_W-1:0] clamp32(longint x);
    if (x > Q_MAX) return rsc_pkg::SAT_MAX;
    if (x < Q_MIN) return rsc_pkg::SAT_MIN;
    return x[rsc_pkg::DATA_W-1:0];
  endfunction

  // floor root of v * 2^16, built one root bit at a time from the top
  function automatic logic signed [rsc_pkg::DATA_W-1:0] q16_root(
      logic signed [rsc_pkg::DATA_W-1:0] v);
    longint x;
    longint r;
    longint t;
    x = longint'(v) <<< 16;
    r = 0;
    for (int i = rsc_pkg::ROOT_W - 1; i >= 0; i--) begin
      t = r | (64'sd1 << i);
      if (t * t <= x) r = t;
    end
    return r[rsc_pkg::DATA_W-1:0];
  endfunction

  // two-operand arithmetic, a is the lower entry and b the top
  function automatic logic signed [rsc_pkg::DATA_W-1:0] q16_binop(
      logic [rsc_pkg::CODE_W-1:0] kind, longint a, longint b);
    longint r;
    case (kind)
      rsc_pkg::KIND_ADD: r = a + b;
      rsc_pkg::KIND_SUB: r = a - b;
      rsc_pkg::KIND_MUL: r = (a * b) >>> 16;
      default:           r = (a <<< 16) / b;
    endcase
    return clamp32(r);
  endfunction

  // advance the shadow state by one accepted item
  task automatic eval_token(rsc_pkg::in_item_t tok);
    rsc_pkg::out_item_t res;
    longint             a;
    longint             b;
    if (tok.kind == rsc_pkg::KIND_END) begin
      res.status = shadow_err;
      res.answer = '0;
      if (shadow_err == rsc_pkg::ERR_NONE) begin
        if (shadow_count == 1) res.answer = shadow_stack[0];
        else res.status = rsc_pkg::ERR_LEFT;
      end
      answers_q.push_back(res);
      shadow_count = 0;
      shadow_err   = rsc_pkg::ERR_NONE;
    end else if (shadow_err == rsc_pkg::ERR_NONE) begin
      case (tok.kind)
        rsc_pkg::KIND_PUSH: begin
          if (shadow_count >= DEPTH) begin
            shadow_err = rsc_pkg::ERR_OVF;
          end else begin
            shadow_stack[shadow_count] = tok.operand;
            shadow_count++;
          end
        end
        rsc_pkg::KIND_SQRT: begin
          if (shadow_count < 1) shadow_err = rsc_pkg::ERR_FEW;
          else if (shadow_stack[shadow_count-1] < 0) shadow_err = rsc_pkg::ERR_NEG;
          else shadow_stack[shadow_count-1] = q16_root(shadow_stack[shadow_count-1]);
        end
        rsc_pkg::KIND_ADD, rsc_pkg::KIND_SUB, rsc_pkg::KIND_MUL, rsc_pkg::KIND_DIV: begin
          if (shadow_count < 2) begin
            shadow_err = rsc_pkg::ERR_FEW;
          end else begin
            b = shadow_stack[shadow_count-1];
            a = shadow_stack[shadow_count-2];
            if (tok.kind == rsc_pkg::KIND_DIV && b == 0) begin
              shadow_err = rsc_pkg::ERR_DIV0;
            end else begin
              shadow_stack[shadow_count-2] = q16_binop(tok.kind, a, b);
              shadow_count--;
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  // compare results first, then predict from the item taken at the same edge
  always @(posedge clk) begin
    rsc_pkg::out_item_t want;
    if (!rst_n) begin
      shadow_count = 0;
      shadow_err   = rsc_pkg::ERR_NONE;
      mismatches   = 0;
      answers_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (answers_q.size() == 0) begin
          $display("%0t: unexpected result status %0d answer %h",
                   $time, out_data.status, out_data.answer);
          mismatches++;
        end else begin
          want = answers_q.pop_front();
          if (out_data.status !== want.status || out_data.answer !== want.answer) begin
            $display("%0t: mismatch expected status %0d answer %h, got status %0d answer %h",
                     $time, want.status, want.answer, out_data.status, out_data.answer);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) eval_token(in_data);
    end
    pending = answers_q.size();
  end

endmodule

>>> dv/tb.sv
module tb;

  localparam int                         DEPTH       = 8;
  localparam int                         N_ITEMS     = 1300;
  localparam int                         CALM_ITEMS  = 250;
  localparam logic [rsc_pkg::CODE_W-1:0] KIND_UNUSED = 3'd7;
  localparam logic [rsc_pkg::DATA_W-1:0] Q_ONE       = 32'h0001_0000;
  localparam logic [rsc_pkg::DATA_W-1:0] Q_NEG_LSB   = 32'hFFFF_FFFF;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  rsc_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  rsc_pkg::out_item_t out_data;
  int                 mismatches;
  int                 pending;
  int                 sent;
  bit                 stall_en = 1'b1;

  always #2 clk = ~clk;

  rpn_stack_calculator_core #(
    .STACK_DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  rpn_checker #(
    .DEPTH(DEPTH)
  ) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // watchdog
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side back-pressure in short bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_en && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // offer one item and hold it until taken
  task automatic send_token(logic [rsc_pkg::CODE_W-1:0] kind,
                            logic [rsc_pkg::DATA_W-1:0] val);
    if (stall_en && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_data.kind    = kind;
    in_data.operand = val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // mix of zero, extremes, small fixed-point values and raw bits
  function automatic logic [rsc_pkg::DATA_W-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return rsc_pkg::SAT_MAX;
      2:       return rsc_pkg::SAT_MIN;
      3, 4:    return $urandom_range(0, 40 << 16) - (20 << 16);
      5:       return $urandom_range(1, 300) << 16;
      6:       return $urandom_range(0, 65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [rsc_pkg::CODE_W-1:0] rand_binop();
    case ($urandom_range(0, 3))
      0:       return rsc_pkg::KIND_ADD;
      1:       return rsc_pkg::KIND_SUB;
      2:       return rsc_pkg::KIND_MUL;
      default: return rsc_pkg::KIND_DIV;
    endcase
  endfunction

  // well-formed expression: stack depth tracked so every op has its operands
  task automatic run_expression();
    int depth;
    int steps;
    depth = 0;
    steps = $urandom_range(1, 14);
    repeat (steps) begin
      if (depth < 1 || (depth < DEPTH && $urandom_range(0, 1) == 0)) begin
        send_token(rsc_pkg::KIND_PUSH, rand_operand());
        depth++;
      end else if (depth == 1 || $urandom_range(0, 5) == 0) begin
        send_token(rsc_pkg::KIND_SQRT, $urandom);
      end else begin
        send_token(rand_binop(), $urandom);
        depth--;
      end
    end
    while (depth > 1) begin
      send_token(rand_binop(), $urandom);
      depth--;
    end
    send_token(rsc_pkg::KIND_END, $urandom);
  endtask

  // broken sequences: random kinds, or a push run to or past the stack top
  task automatic run_noise();
    if ($urandom_range(0, 2) == 0) begin
      repeat (DEPTH + $urandom_range(0, 2)) send_token(rsc_pkg::KIND_PUSH, rand_operand());
      if ($urandom_range(0, 1) == 0) send_token(rand_binop(), $urandom);
    end else begin
      repeat ($urandom_range(1, 10)) begin
        send_token(rsc_pkg::CODE_W'($urandom_range(0, 7)), rand_operand());
      end
    end
    send_token(rsc_pkg::KIND_END, $urandom);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    sent     = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // end on an empty stack
    send_token(rsc_pkg::KIND_END, '0);
    // saturating add, subtract and multiply
    send_token(rsc_pkg::KIND_PUSH, rsc_pkg::SAT_MAX);
    send_token(rsc_pkg::KIND_PUSH, rsc_pkg::SAT_MAX);
    send_token(rsc_pkg::KIND_ADD, '0);
    send_token(rsc_pkg::KIND_PUSH, rsc_pkg::SAT_MIN);
    send_token(rsc_pkg::KIND_SUB, '0);
    send_token(rsc_pkg::KIND_PUSH, rsc_pkg::SAT_MIN);
    send_token(rsc_pkg::KIND_MUL, '0);
    send_token(rsc_pkg::KIND_END, '0);
    // divide at the negative limit, then divide by zero
    send_token(rsc_pkg::KIND_PUSH, rsc_pkg::SAT_MIN);
    send_token(rsc_pkg::KIND_PUSH, Q_ONE);
    send_token(rsc_pkg::KIND_DIV, '0);
    send_token(rsc_pkg::KIND_PUSH, '0);
    send_token(rsc_pkg::KIND_DIV, '0);
    send_token(rsc_pkg::KIND_END, '0);
    // root with nothing on the stack
    send_token(rsc_pkg::KIND_SQRT, '0);
    send_token(rsc_pkg::KIND_END, '0);
    // largest root, negative root, unused kind after the error
    send_token(rsc_pkg::KIND_PUSH, rsc_pkg::SAT_MAX);
    send_token(rsc_pkg::KIND_SQRT, '0);
    send_token(rsc_pkg::KIND_PUSH, Q_NEG_LSB);
    send_token(rsc_pkg::KIND_SQRT, '0);
    send_token(KIND_UNUSED, '0);
    send_token(rsc_pkg::KIND_END, '0);

    // random expressions, mostly well formed; no idling near the end
    while (sent < N_ITEMS) begin
      if (sent > N_ITEMS - CALM_ITEMS) stall_en = 1'b0;
      if ($urandom_range(0, 3) != 0) run_expression();
      else run_noise();
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/rsc_pkg.sv
sv/rpn_stack_calculator_core.sv
dv/rpn_checker.sv
dv/tb.sv
